### hw/rtl/tbts_pkg.sv
// ============================================================================
// tbts_pkg: shared types and constants of the timed button tap sequencer
// Holds the beat payloads, the register file view, the sequencer state and
// the phase, opcode and register index codes.
// ============================================================================
package tbts_pkg;

    localparam int MAX_TAPS = 255;
    localparam logic [7:0] TAP_LIMIT = 8'((MAX_TAPS > 255) ? 255 : MAX_TAPS);

    localparam logic [63:0] TIME_MAX = {64{1'b1}};

    // Phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HOLD    = 3'd1;
    localparam logic [2:0] PH_GAP     = 3'd2;
    localparam logic [2:0] PH_PRESS   = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    // Opcodes
    localparam logic [1:0] OP_POLL   = 2'd0;
    localparam logic [1:0] OP_TAPS   = 2'd1;
    localparam logic [1:0] OP_QUICK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_HOLD    = 3'd0;
    localparam logic [2:0] REG_GAP     = 3'd1;
    localparam logic [2:0] REG_PRESS   = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_MASK    = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  tap_req;
        logic [63:0] now_ms;
        logic [15:0] buttons_in;
    } tbts_in_t;

    typedef struct packed {
        logic [15:0] buttons_out;
        logic [2:0]  phase_out;
        logic [7:0]  taps_left;
    } tbts_out_t;

    typedef struct packed {
        logic [11:0] hold_time_ms;
        logic [11:0] gap_time_ms;
        logic [11:0] press_time_ms;
        logic [11:0] release_time_ms;
        logic [15:0] button_mask;
    } tbts_cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] deadline;
        logic [7:0]  taps;
    } tbts_state_t;

    // Saturating add of a short duration to a timestamp.
    function automatic logic [63:0] sat_add(input logic [63:0] t, input logic [11:0] d);
        logic [64:0] s;
        s = {1'b0, t} + {53'd0, d};
        return s[64] ? TIME_MAX : s[63:0];
    endfunction

endpackage

### hw/rtl/tbts_cfg.sv
// ============================================================================
// tbts_cfg: configuration register file
// Five timing and mask registers written through the configuration channel.
// Writes to an index beyond the list are taken and dropped.
// ============================================================================
module tbts_cfg import tbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    output tbts_cfg_t   cfg
);

    tbts_cfg_t cfg_reg;
    tbts_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_HOLD:    cfg_next.hold_time_ms    = wr_data[11:0];
                REG_GAP:     cfg_next.gap_time_ms     = wr_data[11:0];
                REG_PRESS:   cfg_next.press_time_ms   = wr_data[11:0];
                REG_RELEASE: cfg_next.release_time_ms = wr_data[11:0];
                REG_MASK:    cfg_next.button_mask     = wr_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms    <= 12'd260;
            cfg_reg.gap_time_ms     <= 12'd100;
            cfg_reg.press_time_ms   <= 12'd60;
            cfg_reg.release_time_ms <= 12'd90;
            cfg_reg.button_mask     <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/tbts_step.sv
// ============================================================================
// tbts_step: one sequencer step
// Applies any queueing from the beat, then advances the phase once and
// builds the result word. Pure combinational logic between the input
// register and the state and result registers.
// ============================================================================
module tbts_step import tbts_pkg::*;
(
    input  tbts_in_t    item,
    input  tbts_state_t state,
    input  tbts_cfg_t   cfg,
    output tbts_state_t state_next,
    output tbts_out_t   result
);

    logic [7:0]  count;
    logic [11:0] q_dur;
    logic        queued;
    tbts_state_t eff;
    logic        reached;
    logic [11:0] step_dur;
    logic [63:0] step_dl;
    logic        drive;
    logic        now_max;

    always_comb
    begin
        count   = (item.tap_req > TAP_LIMIT) ? TAP_LIMIT : item.tap_req;
        now_max = (item.now_ms == TIME_MAX);
        queued  = 1'b0;
        q_dur   = cfg.press_time_ms;
        eff     = state;

        unique case (item.opcode)
            OP_TAPS:
            begin
                if (count == 8'd0)
                begin
                    eff.phase    = PH_IDLE;
                    eff.deadline = 64'd0;
                    eff.taps     = 8'd0;
                end
                else
                begin
                    queued       = 1'b1;
                    q_dur        = cfg.press_time_ms;
                    eff.phase    = PH_PRESS;
                    eff.deadline = sat_add(item.now_ms, cfg.press_time_ms);
                    eff.taps     = count;
                end
            end
            OP_QUICK:
            begin
                queued       = 1'b1;
                q_dur        = cfg.hold_time_ms;
                eff.phase    = PH_HOLD;
                eff.deadline = sat_add(item.now_ms, cfg.hold_time_ms);
                eff.taps     = count;
            end
            OP_POLL, OP_UNUSED: eff = state;
            default:            eff = state;
        endcase

        // A freshly queued deadline is reached at once only when its
        // duration is zero or the add saturated at the current time.
        if (queued)
            reached = (q_dur == 12'd0) || now_max;
        else
            reached = (item.now_ms >= state.deadline);

        unique case (eff.phase)
            PH_HOLD:            step_dur = cfg.gap_time_ms;
            PH_GAP, PH_RELEASE: step_dur = cfg.press_time_ms;
            PH_PRESS:           step_dur = cfg.release_time_ms;
            default:            step_dur = 12'd0;
        endcase
        step_dl = sat_add(item.now_ms, step_dur);

        drive      = 1'b0;
        state_next = eff;
        unique case (eff.phase)
            PH_HOLD:
            begin
                if (!reached)
                    drive = 1'b1;
                else
                begin
                    state_next.phase    = PH_GAP;
                    state_next.deadline = step_dl;
                end
            end
            PH_GAP, PH_RELEASE:
            begin
                if (reached)
                begin
                    if (eff.taps == 8'd0)
                    begin
                        state_next.phase    = PH_IDLE;
                        state_next.deadline = 64'd0;
                    end
                    else
                    begin
                        state_next.phase    = PH_PRESS;
                        state_next.deadline = step_dl;
                        drive               = 1'b1;
                    end
                end
            end
            PH_PRESS:
            begin
                if (eff.taps == 8'd0)
                begin
                    state_next.phase    = PH_IDLE;
                    state_next.deadline = 64'd0;
                end
                else
                begin
                    drive = 1'b1;
                    if (reached)
                    begin
                        state_next.taps     = eff.taps - 8'd1;
                        state_next.phase    = PH_RELEASE;
                        state_next.deadline = step_dl;
                    end
                end
            end
            default: state_next.phase = PH_IDLE;
        endcase

        result.buttons_out = (item.buttons_in & ~cfg.button_mask)
                           | (drive ? cfg.button_mask : 16'd0);
        result.phase_out   = state_next.phase;
        result.taps_left   = state_next.taps;
    end

endmodule

### hw/rtl/timed_button_tap_sequencer.sv
// ============================================================================
// timed_button_tap_sequencer: timed button tap injector
// Replaces the owned bits of a polled button word with synthetic hold and
// tap trains, one poll per beat.
// ============================================================================
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_ready, in_data    | sink
//  out     | out_valid, out_ready, out_data | source
//  cfg     | cfg_valid, cfg_ready,          | sink
//          | cfg_index, cfg_data            |
//
// A beat is registered on entry in item_reg, stepped against the sequencer
// state, and the result lands in the output register, one beat per cycle
// sustained while the output is not held. The state update is a compare and
// saturating adds on the timestamp.
// Reset clears the state to idle and loads the register defaults.
// A held output stalls the input register, and in_ready falls with it.
// The configuration channel is always ready.
module timed_button_tap_sequencer import tbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tbts_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tbts_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tbts_cfg_t   cfg;
    tbts_in_t    item_reg;
    logic        item_valid_reg;
    tbts_state_t state_reg;
    tbts_state_t state_next;
    tbts_out_t   result;
    tbts_out_t   out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;

    tbts_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tbts_step u_step
    (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (advance)
            out_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{phase: PH_IDLE, deadline: 64'd0, taps: 8'd0};
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_RELEASE)
        else $error("sequencer phase out of range");

    a_idle_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.deadline == 64'd0)
        else $error("idle phase with a pending deadline");

    a_press_taps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PRESS |-> state_reg.taps != 8'd0)
        else $error("press phase with no taps left");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && out_reg.phase_out == state_reg.phase)
        else $error("stepped beat did not reach the output register");
`endif

endmodule
